>>> hw/rtl/u8v_pkg.sv
// Shared types, constants and lookup functions for the UTF-8 validator.
// Used by u8v_front, u8v_queue, u8v_back and utf8_dfa_validator.
package u8v_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int CP_BITS     = 21;
  localparam int PCOUNT_BITS = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // character classes
  localparam logic [3:0] CL_ASCII   = 4'd0;
  localparam logic [3:0] CL_CONT80  = 4'd1;
  localparam logic [3:0] CL_LEAD2   = 4'd2;
  localparam logic [3:0] CL_LEAD3   = 4'd3;
  localparam logic [3:0] CL_ED      = 4'd4;
  localparam logic [3:0] CL_F4      = 4'd5;
  localparam logic [3:0] CL_LEAD4   = 4'd6;
  localparam logic [3:0] CL_CONTA0  = 4'd7;
  localparam logic [3:0] CL_BAD     = 4'd8;
  localparam logic [3:0] CL_CONT90  = 4'd9;
  localparam logic [3:0] CL_E0      = 4'd10;
  localparam logic [3:0] CL_F0      = 4'd11;

  typedef enum logic [3:0] {
    ST_ACCEPT = 4'd0,
    ST_REJECT = 4'd1,
    ST_P2     = 4'd2,
    ST_P3     = 4'd3,
    ST_P4     = 4'd4,
    ST_P5     = 4'd5,
    ST_P6     = 4'd6,
    ST_P7     = 4'd7,
    ST_P8     = 4'd8
  } dfa_state_t;

  // classified request passed from front to back
  typedef struct packed {
    logic       term;
    logic [3:0] cls;
    logic [7:0] data;
  } u8v_item_t;

  typedef logic [3:0] dfa_row_t [12];

  localparam dfa_row_t DFA_TBL [9] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b < 8'h80)       c = CL_ASCII;
    else if (b < 8'h90)  c = CL_CONT80;
    else if (b < 8'hA0)  c = CL_CONT90;
    else if (b < 8'hC0)  c = CL_CONTA0;
    else if (b < 8'hC2)  c = CL_BAD;
    else if (b < 8'hE0)  c = CL_LEAD2;
    else if (b == 8'hE0) c = CL_E0;
    else if (b == 8'hED) c = CL_ED;
    else if (b < 8'hF0)  c = CL_LEAD3;
    else if (b == 8'hF0) c = CL_F0;
    else if (b < 8'hF4)  c = CL_LEAD4;
    else if (b == 8'hF4) c = CL_F4;
    else                 c = CL_BAD;
    return c;
  endfunction

  function automatic dfa_state_t dfa_next(input dfa_state_t st, input logic [3:0] cls);
    dfa_state_t ns;
    if (st > ST_P8 || cls > CL_F0) ns = ST_REJECT;
    else ns = dfa_state_t'(DFA_TBL[st][cls]);
    return ns;
  endfunction

endpackage

>>> hw/rtl/u8v_front.sv
// Front stage: takes input bytes, classifies them and registers the request.
// Depends on u8v_pkg; feeds u8v_queue.
module u8v_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  output logic              push_valid,
  input  logic              push_stall,
  output u8v_pkg::u8v_item_t push_item
);
  import u8v_pkg::*;

  logic      valid_r, valid_nxt;
  u8v_item_t item_r, item_nxt;
  logic      accept;

  assign in_stall = valid_r && push_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
    if (accept) begin
      item_nxt.term = (in_data_byte == 8'h00);
      item_nxt.cls  = byte_class(in_data_byte);
      item_nxt.data = in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

>>> hw/rtl/u8v_queue.sv
// Short request queue between the front and back stages.
// Depends on u8v_pkg for the item type and depth.
module u8v_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_stall,
  input  u8v_pkg::u8v_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output u8v_pkg::u8v_item_t pop_item
);
  import u8v_pkg::*;

  u8v_item_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  localparam logic [QPTR_BITS-1:0] LAST_PTR = QPTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_BITS-1:0] FULL_CNT = QCNT_BITS'(QUEUE_DEPTH);

  assign push_stall = (cnt_r == FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

>>> hw/rtl/u8v_back.sv
// Back stage: runs the UTF-8 DFA, accumulator and point counter per request
// and holds the result register. Depends on u8v_pkg; fed by u8v_queue.
module u8v_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  u8v_pkg::u8v_item_t                 pop_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [u8v_pkg::CP_BITS-1:0]        out_code_point,
  output logic                               out_point_complete,
  output logic                               out_rejected,
  output logic [u8v_pkg::PCOUNT_BITS-1:0]    out_point_count,
  output logic                               out_string_end,
  output logic                               out_string_invalid
);
  import u8v_pkg::*;

  dfa_state_t             state_r, state_nxt;
  logic [CP_BITS-1:0]     acc_r, acc_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;

  logic                   ovalid_r, ovalid_nxt;
  logic [CP_BITS-1:0]     ocp_r, ocp_nxt;
  logic                   ocomp_r, ocomp_nxt;
  logic                   orej_r, orej_nxt;
  logic [PCOUNT_BITS-1:0] ocnt_r, ocnt_nxt;
  logic                   oend_r, oend_nxt;
  logic                   oinv_r, oinv_nxt;

  logic                   take;
  dfa_state_t             ns;
  logic [7:0]             lead_mask;

  assign pop_ready = !ovalid_r || !out_stall;
  assign take      = pop_valid && pop_ready;
  assign ns        = dfa_next(state_r, pop_item.cls);
  assign lead_mask = 8'hFF >> pop_item.cls;

  // DFA, accumulator and counter
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    if (take) begin
      if (pop_item.term) begin
        state_nxt = ST_ACCEPT;
        acc_nxt   = '0;
        count_nxt = '0;
      end else begin
        state_nxt = ns;
        if (state_r != ST_ACCEPT) acc_nxt = {acc_r[CP_BITS-7:0], pop_item.data[5:0]};
        else acc_nxt = CP_BITS'(lead_mask & pop_item.data);
        if (ns == ST_ACCEPT && count_r != COUNT_MAX) count_nxt = count_r + 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    ovalid_nxt = ovalid_r;
    ocp_nxt    = ocp_r;
    ocomp_nxt  = ocomp_r;
    orej_nxt   = orej_r;
    ocnt_nxt   = ocnt_r;
    oend_nxt   = oend_r;
    oinv_nxt   = oinv_r;
    if (pop_ready) ovalid_nxt = pop_valid;
    if (take) begin
      if (pop_item.term) begin
        ocp_nxt   = '0;
        ocomp_nxt = 1'b0;
        orej_nxt  = (state_r == ST_REJECT);
        ocnt_nxt  = PCOUNT_BITS'(count_r);
        oend_nxt  = 1'b1;
        oinv_nxt  = (state_r != ST_ACCEPT);
      end else begin
        ocp_nxt   = (ns == ST_ACCEPT) ? acc_nxt : '0;
        ocomp_nxt = (ns == ST_ACCEPT);
        orej_nxt  = (ns == ST_REJECT);
        ocnt_nxt  = PCOUNT_BITS'(count_nxt);
        oend_nxt  = 1'b0;
        oinv_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_ACCEPT;
      acc_r    <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    ocp_r   <= ocp_nxt;
    ocomp_r <= ocomp_nxt;
    orej_r  <= orej_nxt;
    ocnt_r  <= ocnt_nxt;
    oend_r  <= oend_nxt;
    oinv_r  <= oinv_nxt;
  end

  assign out_valid          = ovalid_r;
  assign out_code_point     = ocp_r;
  assign out_point_complete = ocomp_r;
  assign out_rejected       = orej_r;
  assign out_point_count    = ocnt_r;
  assign out_string_end     = oend_r;
  assign out_string_invalid = oinv_r;

  // reject holds until a terminator
  a_reject_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REJECT && !(take && pop_item.term)) |=> (state_r == ST_REJECT))
    else $error("reject state left without terminator");

  // saturated count stays saturated within a string
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == COUNT_MAX && !(take && pop_item.term)) |=> (count_r == COUNT_MAX))
    else $error("point count wrapped");

  // a completed point and reject cannot be reported together
  a_comp_rej: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !(ocomp_r && orej_r))
    else $error("point complete while rejected");

  // terminator result carries no code point, and state is cleared after it
  a_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (take && pop_item.term) |=> (oend_r && !ocomp_r && ocp_r == '0
                                 && state_r == ST_ACCEPT && count_r == '0))
    else $error("terminator result or clear wrong");

endmodule

>>> hw/rtl/utf8_dfa_validator.sv
// UTF-8 validator: one byte per request in, one result per byte out.
// Path: a byte passes the front classify register and then a queue slot; the back stage then pops it
// and registers its result, raising out_valid.
// Throughput: one byte per cycle while out_stall is low, set by the DFA step in the back stage.
// Reset (synchronous, rst_n low) empties the pipeline and clears DFA state,
// accumulator and point count; no clearing pass is needed.
module utf8_dfa_validator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [u8v_pkg::CP_BITS-1:0]     out_code_point,
  output logic                            out_point_complete,
  output logic                            out_rejected,
  output logic [u8v_pkg::PCOUNT_BITS-1:0] out_point_count,
  output logic                            out_string_end,
  output logic                            out_string_invalid
);
  import u8v_pkg::*;

  logic      push_valid, push_stall;
  u8v_item_t push_item;
  logic      pop_valid, pop_ready;
  u8v_item_t pop_item;

  u8v_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .push_valid   (push_valid),
    .push_stall   (push_stall),
    .push_item    (push_item)
  );

  u8v_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  u8v_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_item           (pop_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_code_point     (out_code_point),
    .out_point_complete (out_point_complete),
    .out_rejected       (out_rejected),
    .out_point_count    (out_point_count),
    .out_string_end     (out_string_end),
    .out_string_invalid (out_string_invalid)
  );

endmodule
